// ----- src/pft_pkg.sv -----
// shared types, command codes and sizing constants for the page frame table
package pft_pkg;

    // default table size and the widest address the table may need
    localparam int FRAMES_DEF = 128;
    localparam int ADDR_MAX_W = 10;

    // field widths of one beat
    localparam int PID_W   = 8;
    localparam int VPG_W   = 8;
    localparam int NEED_W  = 8;
    localparam int FRAME_W = 7;
    localparam int FC_W    = 8;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CHECK   = 2'd3
    } t_cmd;

    // one table entry as stored in the frame memory
    typedef struct packed {
        logic             used;
        logic [PID_W-1:0] owner;
        logic [VPG_W-1:0] vpage;
    } t_entry;

    // access request from the sequencer to the frame memory
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        t_entry                wr_data;
    } t_mem_req;

    // one result beat
    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
        logic [FC_W-1:0]    free_count;
    } t_result;

endpackage

// ----- src/pft_mem.sv -----
// frame memory: one write port, one read port with registered read data
module pft_mem
    import pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    localparam int AW = $clog2(FRAMES);

    t_entry r_mem [FRAMES];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // read port, read data registered in the cycle after the read request
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/pft_scan.sv -----
// command sequencer: clears the memory, scans entries, updates them, holds the result beat
module pft_scan
    import pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command beat
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic [PID_W-1:0]  i_pid,
    input  logic [VPG_W-1:0]  i_vpg,
    input  logic [NEED_W-1:0] i_need,
    // frame memory
    output t_mem_req          o_req,
    input  t_entry            i_rd_data,
    // result beat
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    localparam int AW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_more, n_more;
    logic                r_chk_valid;
    logic [AW-1:0]       r_chk_addr;
    logic [CW-1:0]       r_count, n_count;
    t_cmd                r_cmd, n_cmd;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic [VPG_W-1:0]    r_vpg, n_vpg;
    logic [NEED_W-1:0]   r_need, n_need;
    logic                r_res_ok, n_res_ok;
    logic [AW-1:0]       r_res_idx, n_res_idx;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;
    t_mem_req            req;
    logic                owner_hit;
    logic [FC_W-1:0]     fc_sat;
    logic                enough;

    // owner match on the entry that has just been read
    assign owner_hit = i_rd_data.used && (i_rd_data.owner == r_pid);

    // free count saturated to the result field, and the check command's answer
    assign fc_sat = (XW'(r_count) > XW'(255)) ? FC_W'(255) : FC_W'(r_count);
    assign enough = XW'(r_count) >= XW'(r_need);

    // next state and memory requests
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_more      = r_more;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_pid       = r_pid;
        n_vpg       = r_vpg;
        n_need      = r_need;
        n_res_ok    = r_res_ok;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        req         = '0;

        unique case (r_state)
            // sweep every entry to free after reset
            S_CLEAR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = ADDR_MAX_W'(r_addr);
                req.wr_data = '0;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end

            // take a command beat
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_pid     = i_pid;
                    n_vpg     = i_vpg;
                    n_need    = i_need;
                    n_res_ok  = (i_cmd == CMD_RELEASE);
                    n_res_idx = '0;
                    n_addr    = '0;
                    n_more    = 1'b1;
                    n_state   = (i_cmd == CMD_CHECK) ? S_DONE : S_SCAN;
                end
            end

            // issue reads in order and act on each returned entry
            S_SCAN: begin
                if (r_more) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = ADDR_MAX_W'(r_addr);
                    if (r_addr == LAST) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_chk_valid) begin
                    if (r_chk_addr == LAST) begin
                        n_state = S_DONE;
                    end
                    unique case (r_cmd)
                        CMD_LOOKUP: begin
                            if (owner_hit && (i_rd_data.vpage == r_vpg)) begin
                                n_res_ok  = 1'b1;
                                n_res_idx = r_chk_addr;
                                n_state   = S_DONE;
                            end
                        end
                        CMD_ALLOC: begin
                            if (!i_rd_data.used) begin
                                req.wr_en         = 1'b1;
                                req.wr_addr       = ADDR_MAX_W'(r_chk_addr);
                                req.wr_data.used  = 1'b1;
                                req.wr_data.owner = r_pid;
                                req.wr_data.vpage = r_vpg;
                                n_count           = r_count - CW'(1);
                                n_res_ok          = 1'b1;
                                n_res_idx         = r_chk_addr;
                                n_state           = S_DONE;
                            end
                        end
                        CMD_RELEASE: begin
                            if (owner_hit) begin
                                req.wr_en        = 1'b1;
                                req.wr_addr      = ADDR_MAX_W'(r_chk_addr);
                                req.wr_data      = i_rd_data;
                                req.wr_data.used = 1'b0;
                                n_count          = r_count + CW'(1);
                            end
                        end
                        CMD_CHECK: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.ok         = (r_cmd == CMD_CHECK) ? enough : r_res_ok;
                    n_out.frame      = FRAME_W'(r_res_idx);
                    n_out.free_count = fc_sat;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counters and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_more      <= 1'b0;
            r_chk_valid <= 1'b0;
            r_count     <= CW'(FRAMES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_more      <= n_more;
            r_chk_valid <= req.rd_en;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_chk_addr <= r_addr;
        r_cmd      <= n_cmd;
        r_pid      <= n_pid;
        r_vpg      <= n_vpg;
        r_need     <= n_need;
        r_res_ok   <= n_res_ok;
        r_res_idx  <= n_res_idx;
        r_out      <= n_out;
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_req       = req;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ----- src/page_frame_table.sv -----
// top level of the page frame table: stream ports, sequencer and frame memory
//
// Physical page frame table with lookup, allocate-first-free, release-by-process and
// free-count check commands, one result beat per command. Lookup, allocate and release
// walk the frame memory one entry per cycle through its single read port (lookup and
// allocate stop at the first match); a free-count check skips the walk. After reset the
// memory is swept to free, during which no command beat is taken. A finished result may
// wait in the output register while the next command is already being worked on.
module page_frame_table
    import pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // proc_id[7:0], virt_page[15:8], needed[23:16]
    input  logic [1:0]  i_s_tuser,   // cmd[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // frame[6:0], free_count[14:7], zero[15]
    output logic        o_m_tuser    // ok[0]
);

    t_mem_req mem_req;
    t_entry   mem_rd_data;
    t_result  res;

    // sequencer
    pft_scan #(
        .FRAMES(FRAMES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_tvalid),
        .o_cmd_ready (o_s_tready),
        .i_cmd       (t_cmd'(i_s_tuser)),
        .i_pid       (i_s_tdata[7:0]),
        .i_vpg       (i_s_tdata[15:8]),
        .i_need      (i_s_tdata[23:16]),
        .o_req       (mem_req),
        .i_rd_data   (mem_rd_data),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    // frame memory
    pft_mem #(
        .FRAMES(FRAMES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // result beat packing
    assign o_m_tdata = {1'b0, res.free_count, res.frame};
    assign o_m_tuser = res.ok;

endmodule

// ----- src/pft_checker.sv -----
// port checker for the page frame table and its bind
module pft_checker
    import pft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    localparam int FC_MAX = (FRAMES > 255) ? 255 : FRAMES;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while another is in progress");

    // free count never above the table size
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[14:7] <= FC_W'(FC_MAX))
        else $error("free count above table size");

    // a failed command reports frame zero
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[6:0] == '0)
        else $error("nonzero frame on a failed command");

endmodule

bind page_frame_table pft_checker #(.FRAMES(FRAMES)) u_pft_checker (.*);

// ----- sim/page_frame_table_tb.sv -----
// self-checking testbench for the page frame table: command stream in, result stream out
`timescale 1ns / 100ps

module page_frame_table_tb;
    import pft_pkg::*;

    localparam int FRAMES      = FRAMES_DEF;
    localparam int RAND_ITEMS  = 1150;
    localparam int MODE_LEN    = 200;
    localparam int POOL        = 6;
    localparam int STALL_LIMIT = 4000;

    // traffic shape of one stretch of random commands
    typedef enum int {
        MODE_FILL,
        MODE_MIXED,
        MODE_DRAIN
    } t_mode;

    // mirror of the frame table and the queue of results it expects
    class frame_table_mirror;
        bit        used [FRAMES];
        logic [7:0] owner [FRAMES];
        logic [7:0] vpage [FRAMES];
        t_result   expected_q [$];
        int        errors;
        int        n_cmd [4];
        int        n_hits;
        int        n_full;
        int        n_short;

        function int free_frames();
            int n;
            n = 0;
            for (int i = 0; i < FRAMES; i++) begin
                if (!used[i]) n++;
            end
            return n;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // choose a live (process, page) pair, leaving the arguments alone if none exists
        function bit pick_used(inout logic [7:0] pid, inout logic [7:0] vpg);
            int start;
            int idx;
            start = $urandom_range(FRAMES - 1);
            for (int i = 0; i < FRAMES; i++) begin
                idx = (start + i) % FRAMES;
                if (used[idx]) begin
                    pid = owner[idx];
                    vpg = vpage[idx];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // apply one accepted command beat and queue its result
        function void note_command(t_cmd c, logic [7:0] pid, logic [7:0] vpg,
                                   logic [7:0] need);
            t_result r;
            int      fc;
            int      i;
            r = '0;
            case (c)
                CMD_LOOKUP: begin
                    for (i = 0; i < FRAMES && !r.ok; i++) begin
                        if (used[i] && owner[i] == pid && vpage[i] == vpg) begin
                            r.ok    = 1'b1;
                            r.frame = FRAME_W'(i);
                        end
                    end
                    if (r.ok) n_hits++;
                end
                CMD_ALLOC: begin
                    for (i = 0; i < FRAMES && !r.ok; i++) begin
                        if (!used[i]) begin
                            used[i]  = 1'b1;
                            owner[i] = pid;
                            vpage[i] = vpg;
                            r.ok     = 1'b1;
                            r.frame  = FRAME_W'(i);
                        end
                    end
                    if (!r.ok) n_full++;
                end
                CMD_RELEASE: begin
                    for (i = 0; i < FRAMES; i++) begin
                        if (used[i] && owner[i] == pid) used[i] = 1'b0;
                    end
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            fc = free_frames();
            if (c == CMD_CHECK) begin
                r.ok = (fc >= int'(need));
                if (!r.ok) n_short++;
            end
            r.free_count = (fc > 255) ? 8'hFF : FC_W'(fc);
            n_cmd[c]++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // compare one accepted result beat with the oldest expectation
        function void check_result(logic ok, logic [6:0] frame, logic [7:0] fc, logic pad);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got ok=%0d frame=%0d free=%0d",
                         $time, ok, frame, fc);
                return;
            end
            want = expected_q.pop_front();
            compare_field("ok", 8'(want.ok), 8'(ok));
            compare_field("frame", 8'(want.frame), 8'(frame));
            compare_field("free_count", want.free_count, fc);
            compare_field("pad bit", 8'h00, 8'(pad));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // proc_id[7:0], virt_page[15:8], needed[23:16]
    logic [1:0]  i_s_tuser;   // cmd[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // frame[6:0], free_count[14:7], zero[15]
    logic        o_m_tuser;   // ok[0]

    frame_table_mirror frames = new();
    bit tx_quiet;
    bit rx_quiet;
    int rx_stall;
    int rx_cycles;
    int idle_cycles;

    page_frame_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted beats, then stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            frames.check_result(o_m_tuser, o_m_tdata[6:0], o_m_tdata[14:7], o_m_tdata[15]);
        end
        rx_cycles++;
        if (rx_cycles % 500 == 0) rx_quiet = ($urandom_range(3) == 0);
        if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!rx_quiet && $urandom_range(99) < 15) begin
                rx_stall = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("page_frame_table test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one command beat, wait for it to be taken, then maybe idle
    task automatic send_command(t_cmd c, logic [7:0] pid, logic [7:0] vpg, logic [7:0] need);
        int r;
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {need, vpg, pid};
        i_s_tuser  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        frames.note_command(c, pid, vpg, need);
        r   = $urandom_range(99);
        gap = tx_quiet ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(3, 1) :
              (r < 97) ? $urandom_range(10, 4) : $urandom_range(60, 20);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the command side until every queued result has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (frames.outstanding() != 0);
    endtask

    initial begin
        t_mode      mode;
        t_cmd       c;
        logic [7:0] pool [POOL];
        logic [7:0] pid;
        logic [7:0] vpg;
        logic [7:0] need;
        int         r;
        int         t;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_LOOKUP;
        i_m_tready  = 1'b0;
        idle_cycles = 0;
        rx_stall    = 0;
        rx_cycles   = 0;
        rx_quiet    = 1'b0;
        tx_quiet    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table checks, misses, duplicates, release and reuse
        send_command(CMD_CHECK,   8'h00, 8'h00, 8'd0);
        send_command(CMD_CHECK,   8'hFF, 8'hFF, 8'd128);
        send_command(CMD_CHECK,   8'h00, 8'h00, 8'd129);
        send_command(CMD_CHECK,   8'h00, 8'h00, 8'd255);
        send_command(CMD_LOOKUP,  8'h00, 8'h00, 8'd0);
        send_command(CMD_RELEASE, 8'hFF, 8'h00, 8'd0);
        send_command(CMD_ALLOC,   8'h00, 8'h00, 8'd0);
        send_command(CMD_ALLOC,   8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_ALLOC,   8'h00, 8'hFF, 8'd0);
        send_command(CMD_ALLOC,   8'hFF, 8'h00, 8'd0);
        send_command(CMD_ALLOC,   8'h00, 8'h00, 8'd0);
        send_command(CMD_LOOKUP,  8'h00, 8'h00, 8'd0);
        send_command(CMD_LOOKUP,  8'hFF, 8'hFF, 8'd0);
        send_command(CMD_LOOKUP,  8'h00, 8'h01, 8'd0);
        send_command(CMD_LOOKUP,  8'h01, 8'h00, 8'd0);
        send_command(CMD_RELEASE, 8'h00, 8'h00, 8'd0);
        send_command(CMD_LOOKUP,  8'h00, 8'h00, 8'd0);
        send_command(CMD_ALLOC,   8'h07, 8'h07, 8'd0);
        send_command(CMD_RELEASE, 8'h55, 8'h00, 8'd0);
        send_command(CMD_CHECK,   8'h00, 8'h00, 8'd127);
        send_command(CMD_CHECK,   8'h00, 8'h00, 8'd126);
        send_command(CMD_RELEASE, 8'hFF, 8'h00, 8'd0);
        send_command(CMD_RELEASE, 8'h07, 8'h00, 8'd0);

        // random: stretches that fill, churn or drain the table
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % MODE_LEN == 0) begin
                if (n == MODE_LEN || (n != 0 && $urandom_range(1) == 1)) wait_drained();
                mode     = (n == 0) ? MODE_FILL : t_mode'($urandom_range(2));
                tx_quiet = ($urandom_range(3) == 0);
                for (int k = 0; k < POOL; k++) pool[k] = 8'($urandom_range(255));
                if ($urandom_range(1)) pool[0] = 8'h00;
                if ($urandom_range(1)) pool[1] = 8'hFF;
            end
            pid  = pool[$urandom_range(POOL - 1)];
            vpg  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
            need = 8'($urandom_range(255));
            r    = $urandom_range(99);
            case (mode)
                MODE_FILL:  c = (r < 80) ? CMD_ALLOC : (r < 95) ? CMD_LOOKUP : CMD_CHECK;
                MODE_MIXED: c = (r < 40) ? CMD_ALLOC : (r < 75) ? CMD_LOOKUP :
                                (r < 85) ? CMD_RELEASE : CMD_CHECK;
                default:    c = (r < 25) ? CMD_RELEASE : (r < 60) ? CMD_LOOKUP :
                                (r < 80) ? CMD_ALLOC : CMD_CHECK;
            endcase
            // mostly hit live pairs, probe the boundary of the free count
            if (c == CMD_LOOKUP && $urandom_range(3) != 0) void'(frames.pick_used(pid, vpg));
            if (c == CMD_RELEASE && $urandom_range(9) == 0) pid = 8'($urandom_range(255));
            if (c == CMD_CHECK && $urandom_range(1) == 1) begin
                t = int'($urandom_range(4)) - 2 + frames.free_frames();
                need = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
            end
            // occasional noise beat
            if ($urandom_range(19) == 0) begin
                c   = t_cmd'($urandom_range(3));
                pid = 8'($urandom_range(255));
                vpg = 8'($urandom_range(255));
            end
            send_command(c, pid, vpg, need);
        end

        // let everything drain, then allow one full table walk for stray beats
        wait_drained();
        repeat (FRAMES + 20) @(posedge i_clk);

        $display("covered %0d lookups (%0d hits), %0d allocations (%0d on a full table)",
                 frames.n_cmd[CMD_LOOKUP], frames.n_hits, frames.n_cmd[CMD_ALLOC],
                 frames.n_full);
        $display("and %0d releases, %0d free checks (%0d short), %0d mismatches",
                 frames.n_cmd[CMD_RELEASE], frames.n_cmd[CMD_CHECK], frames.n_short,
                 frames.errors);
        if (frames.errors == 0 && frames.outstanding() == 0) begin
            $display("page_frame_table test passed");
        end else begin
            $display("page_frame_table test failed");
        end
        $finish;
    end

endmodule

// ----- page_frame_table.f -----
src/pft_pkg.sv
src/pft_mem.sv
src/pft_scan.sv
src/page_frame_table.sv
src/pft_checker.sv
sim/page_frame_table_tb.sv
